// ===== design/rsc_pkg.sv =====
// Package for the radix string converter: widths, character codes, register
// indexes and the character decode/encode helpers.
// No dependencies.
package rsc_pkg;

   // digit store depth (8..64) and the widths that follow from it
   localparam int MaxDigits = 64;
   localparam int CountW    = $clog2(MaxDigits + 1);
   localparam int AddrW     = $clog2(MaxDigits);

   // fixed field widths
   localparam int MagW    = 63;
   localparam int RadixW  = 6;
   localparam int ProdW   = MagW + RadixW;
   localparam int BitCntW = $clog2(MagW);
   localparam int SymW    = 8;
   localparam int DataW   = 32;
   localparam int AddrBusW = 3;

   // character codes
   localparam logic [SymW-1:0] CharZero   = 8'h30;
   localparam logic [SymW-1:0] CharNine   = 8'h39;
   localparam logic [SymW-1:0] CharUpperA = 8'h41;
   localparam logic [SymW-1:0] CharUpperZ = 8'h5A;
   localparam logic [SymW-1:0] CharLowerA = 8'h61;
   localparam logic [SymW-1:0] CharLowerZ = 8'h7A;
   localparam logic [SymW-1:0] CharMinus  = 8'h2D;
   localparam logic [SymW-1:0] CharNull   = 8'h00;

   // radix limits and reset values
   localparam logic [RadixW-1:0] RadixMin      = 6'd2;
   localparam logic [RadixW-1:0] RadixMax      = 6'd36;
   localparam logic [RadixW-1:0] DigitTen      = 6'd10;
   localparam logic [RadixW-1:0] SourceReset   = 6'd10;
   localparam logic [RadixW-1:0] TargetReset   = 6'd16;

   // register indexes (address bit 2)
   localparam logic RegSourceRadix = 1'b0;
   localparam logic RegTargetRadix = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [RadixW-1:0] value;
   } digit_type;

   // Clamp a radix register to the legal range.
   function automatic logic [RadixW-1:0] clamp_radix(input logic [RadixW-1:0] r);
      logic [RadixW-1:0] res;
      res = r;
      if (r < RadixMin) res = RadixMin;
      else if (r > RadixMax) res = RadixMax;
      return res;
   endfunction

   // Decode one ASCII character into a digit value 0..35.
   function automatic digit_type digit_decode(input logic [SymW-1:0] c);
      digit_type   res;
      logic [SymW-1:0] off;
      res = '0;
      off = '0;
      if (c inside {[CharZero:CharNine]}) begin
         off = c - CharZero;
         res.valid = 1'b1;
      end else if (c inside {[CharUpperA:CharUpperZ]}) begin
         off = c - CharUpperA + SymW'(DigitTen);
         res.valid = 1'b1;
      end else if (c inside {[CharLowerA:CharLowerZ]}) begin
         off = c - CharLowerA + SymW'(DigitTen);
         res.valid = 1'b1;
      end
      res.value = off[RadixW-1:0];
      return res;
   endfunction

   // Encode a digit value as '0'-'9' or 'A'-'Z'.
   function automatic logic [SymW-1:0] digit_char(input logic [RadixW-1:0] d);
      logic [SymW-1:0] res;
      if (d < DigitTen) res = CharZero + SymW'(d);
      else res = CharUpperA + SymW'(d - DigitTen);
      return res;
   endfunction

endpackage

// ===== design/radix_string_converter_unit.sv =====
// Radix string converter top level: character accumulator, shared
// bit-serial divider, digit store and output sequencer.
// Depends on rsc_pkg.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-------------------------------------
//  request   | start, busy (transfer: start&!busy)| req_symbol, req_ends_number
//  response  | rsp_strobe (one cycle, no stall)   | rsp_out_symbol, rsp_run_end,
//            |                                    | rsp_bad_input, rsp_overflowed
//  config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// Echo mode (equal radices): one character per cycle; the result is registered and
// appears in the cycle after the character is taken. Otherwise a non-final digit
// keeps busy high through multiply, add with saturation and check; a minus, a
// rejected character or any character after an error skips the add. Unless an
// error was seen, the final character then runs the divider for each output digit
// (one quotient bit per cycle over 63 bits, then a store write), then a sign step
// and, per emitted digit, a store read and a show.
// Reset is synchronous and clears all number state; results cannot be stalled.
module radix_string_converter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [rsc_pkg::SymW-1:0]   req_symbol,
   input  logic                       req_ends_number,
   output logic                       rsp_strobe,
   output logic [rsc_pkg::SymW-1:0]   rsp_out_symbol,
   output logic                       rsp_run_end,
   output logic                       rsp_bad_input,
   output logic                       rsp_overflowed,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rsc_pkg::AddrBusW-1:0] paddr,
   input  logic [rsc_pkg::DataW-1:0]  pwdata,
   output logic [rsc_pkg::DataW-1:0]  prdata,
   output logic                       pready
);
   import rsc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_STEP, ST_ADD, ST_CHECK, ST_DIGIT,
      ST_DIV, ST_WRITE, ST_SIGN, ST_READ, ST_SHOW
   } state_type;

   state_type           state_ff, state_in;
   logic [RadixW-1:0]   src_ff, src_in, tgt_ff, tgt_in;
   logic [MagW-1:0]     mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic                first_ff, first_in;
   logic                err_ff, err_in;
   logic                sat_ff, sat_in;
   logic                trunc_ff, trunc_in;
   logic                neg_out_ff, neg_out_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic [AddrW-1:0]    idx_ff, idx_in;
   logic [SymW-1:0]     sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [RadixW-1:0]   d_ff, d_in;
   logic [ProdW-1:0]    prod_ff, prod_in;
   logic [MagW-1:0]     quot_ff, quot_in;
   logic [RadixW-1:0]   rem_ff, rem_in;
   logic [BitCntW-1:0]  bit_ff, bit_in;
   logic                strobe_ff, strobe_in;
   logic [SymW-1:0]     osym_ff, osym_in;
   logic                oend_ff, oend_in;
   logic                obad_ff, obad_in;
   logic                oovf_ff, oovf_in;

   logic [RadixW-1:0]   digit_mem [MaxDigits];
   logic [RadixW-1:0]   rd_data_ff;
   logic                wr_en;

   logic [RadixW-1:0]   src_c, tgt_c;
   logic                accept, cfg_write;
   digit_type           dec;
   logic [ProdW-1:0]    sum;
   logic [RadixW:0]     trial, diff;
   logic                ge;
   logic [CountW-1:0]   cap;

   assign src_c     = clamp_radix(src_ff);
   assign tgt_c     = clamp_radix(tgt_ff);
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign dec       = digit_decode(sym_ff);
   assign sum       = prod_ff + ProdW'(d_ff);
   assign trial     = {rem_ff, quot_ff[MagW-1]};
   assign diff      = trial - {1'b0, tgt_c};
   assign ge        = (trial >= {1'b0, tgt_c});
   assign cap       = CountW'(MaxDigits) - CountW'(neg_out_ff);

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_symbol = osym_ff;
   assign rsp_run_end    = oend_ff;
   assign rsp_bad_input  = obad_ff;
   assign rsp_overflowed = oovf_ff;

   // Return register contents; misaligned reads return zero.
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         case (paddr[2])
            RegSourceRadix: prdata = DataW'(src_ff);
            RegTargetRadix: prdata = DataW'(tgt_ff);
            default:        prdata = '0;
         endcase
      end
   end

   // Next-state logic of the sequencer
   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      tgt_in     = tgt_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      first_in   = first_ff;
      err_in     = err_ff;
      sat_in     = sat_ff;
      trunc_in   = trunc_ff;
      neg_out_in = neg_out_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      sym_in     = sym_ff;
      last_in    = last_ff;
      d_in       = d_ff;
      prod_in    = prod_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      bit_in     = bit_ff;
      strobe_in  = 1'b0;
      osym_in    = osym_ff;
      oend_in    = oend_ff;
      obad_in    = obad_ff;
      oovf_in    = oovf_ff;
      wr_en      = 1'b0;

      // take configuration writes
      if (cfg_write) begin
         case (paddr[2])
            RegSourceRadix: src_in = pwdata[RadixW-1:0];
            RegTargetRadix: tgt_in = pwdata[RadixW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (src_c == tgt_c) begin
                  // echo the character unchanged
                  strobe_in = 1'b1;
                  osym_in   = req_symbol;
                  oend_in   = req_ends_number;
                  obad_in   = 1'b0;
                  oovf_in   = 1'b0;
                  if (req_ends_number) begin
                     mag_in   = '0;
                     neg_in   = 1'b0;
                     first_in = 1'b1;
                     err_in   = 1'b0;
                     sat_in   = 1'b0;
                     count_in = '0;
                  end else begin
                     first_in = 1'b0;
                  end
               end else begin
                  sym_in   = req_symbol;
                  last_in  = req_ends_number;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // classify the character and start the multiply
            first_in = 1'b0;
            state_in = ST_CHECK;
            if (!err_ff) begin
               if (first_ff && sym_ff == CharMinus) begin
                  neg_in = 1'b1;
               end else if (!dec.valid) begin
                  err_in = 1'b1;
               end else begin
                  prod_in  = ProdW'(mag_ff) * ProdW'(src_c);
                  d_in     = dec.value;
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            // fold in the digit, saturate on overflow
            if (sum[ProdW-1:MagW] != '0) begin
               mag_in = '1;
               sat_in = 1'b1;
            end else begin
               mag_in = sum[MagW-1:0];
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (err_ff) begin
               // single error result, then drop the number
               strobe_in = 1'b1;
               osym_in   = CharNull;
               oend_in   = 1'b1;
               obad_in   = 1'b1;
               oovf_in   = 1'b0;
               mag_in    = '0;
               neg_in    = 1'b0;
               first_in  = 1'b1;
               err_in    = 1'b0;
               sat_in    = 1'b0;
               count_in  = '0;
               state_in  = ST_IDLE;
            end else begin
               quot_in    = mag_ff;
               count_in   = '0;
               trunc_in   = 1'b0;
               neg_out_in = neg_ff && (mag_ff != '0);
               state_in   = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            // stop when the store is full, else start one division
            if (count_ff >= cap) begin
               trunc_in = 1'b1;
               state_in = ST_SIGN;
            end else begin
               rem_in   = '0;
               bit_in   = BitCntW'(MagW - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one restoring division step per cycle
            rem_in  = ge ? diff[RadixW-1:0] : trial[RadixW-1:0];
            quot_in = {quot_ff[MagW-2:0], ge};
            bit_in  = bit_ff - 1'b1;
            if (bit_ff == '0) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = (quot_ff == '0) ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (neg_out_ff) begin
               strobe_in = 1'b1;
               osym_in   = CharMinus;
               oend_in   = 1'b0;
               obad_in   = 1'b0;
               oovf_in   = sat_ff || trunc_ff;
            end
            idx_in   = AddrW'(count_ff - 1'b1);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            // emit digits most significant first
            strobe_in = 1'b1;
            osym_in   = digit_char(rd_data_ff);
            oend_in   = (idx_ff == '0);
            obad_in   = 1'b0;
            oovf_in   = sat_ff || trunc_ff;
            if (idx_ff == '0) begin
               mag_in   = '0;
               neg_in   = 1'b0;
               first_in = 1'b1;
               err_in   = 1'b0;
               sat_in   = 1'b0;
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         src_ff     <= SourceReset;
         tgt_ff     <= TargetReset;
         mag_ff     <= '0;
         neg_ff     <= 1'b0;
         first_ff   <= 1'b1;
         err_ff     <= 1'b0;
         sat_ff     <= 1'b0;
         trunc_ff   <= 1'b0;
         neg_out_ff <= 1'b0;
         count_ff   <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         src_ff     <= src_in;
         tgt_ff     <= tgt_in;
         mag_ff     <= mag_in;
         neg_ff     <= neg_in;
         first_ff   <= first_in;
         err_ff     <= err_in;
         sat_ff     <= sat_in;
         trunc_ff   <= trunc_in;
         neg_out_ff <= neg_out_in;
         count_ff   <= count_in;
         strobe_ff  <= strobe_in;
      end
      idx_ff  <= idx_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      osym_ff <= osym_in;
      oend_ff <= oend_in;
      obad_ff <= obad_in;
      oovf_ff <= oovf_in;
   end

   // Digit store: write the remainder, registered read at the show index
   always_ff @(posedge clock) begin
      if (wr_en) digit_mem[count_ff[AddrW-1:0]] <= rem_ff;
      rd_data_ff <= digit_mem[idx_ff];
   end

endmodule

// ===== verif/radix_string_converter_unit_tb.sv =====
// Testbench for radix_string_converter_unit: drives numbers one character at a
// time, predicts every emitted character and checks it; uses rsc_pkg.
`timescale 1ns / 100ps

// Expected-character store plus a bit-true model of the converter.
class conversion_scoreboard;
   typedef struct {
      logic [7:0] sym;
      logic       run_end;
      logic       bad;
      logic       ovf;
   } char_result_type;

   char_result_type expected_chars[$];
   logic [5:0]      source_reg;
   logic [5:0]      target_reg;
   longint unsigned magnitude;
   bit              negative;
   bit              first_char;
   bit              bad_seen;
   bit              saturated;
   int unsigned     errors;
   int unsigned     chars_in;
   int unsigned     chars_out;
   int unsigned     numbers_done;
   int unsigned     bad_numbers;
   int unsigned     sat_numbers;
   int unsigned     echoed;

   function new();
      source_reg = rsc_pkg::SourceReset;
      target_reg = rsc_pkg::TargetReset;
      clear_number();
   endfunction

   function void clear_number();
      magnitude  = 0;
      negative   = 1'b0;
      first_char = 1'b1;
      bad_seen   = 1'b0;
      saturated  = 1'b0;
   endfunction

   function void set_register(logic idx, logic [5:0] value);
      if (idx == rsc_pkg::RegSourceRadix) source_reg = value;
      else target_reg = value;
   endfunction

   function longint unsigned radix_of(logic [5:0] r);
      if (r < rsc_pkg::RadixMin) return rsc_pkg::RadixMin;
      if (r > rsc_pkg::RadixMax) return rsc_pkg::RadixMax;
      return r;
   endfunction

   // Digit value 0..35 of an ASCII character, -1 when it is no digit.
   function int digit_of(logic [7:0] c);
      if (c >= rsc_pkg::CharZero && c <= rsc_pkg::CharNine)
         return c - rsc_pkg::CharZero;
      if (c >= rsc_pkg::CharUpperA && c <= rsc_pkg::CharUpperZ)
         return c - rsc_pkg::CharUpperA + 10;
      if (c >= rsc_pkg::CharLowerA && c <= rsc_pkg::CharLowerZ)
         return c - rsc_pkg::CharLowerA + 10;
      return -1;
   endfunction

   function void push_char(logic [7:0] sym, logic run_end, logic bad, logic ovf);
      char_result_type r;
      r.sym     = sym;
      r.run_end = run_end;
      r.bad     = bad;
      r.ovf     = ovf;
      expected_chars.insert(expected_chars.size(), r);
   endfunction

   // Fold one accepted character into the number; on the last one queue the output.
   function void note_symbol(logic [7:0] sym, logic last);
      longint unsigned src, tgt, dval, m, cap, count;
      longint unsigned sat_mag;
      longint unsigned digit_buf[rsc_pkg::MaxDigits];
      int              d;
      bit              neg_out, trunc, ovf;
      logic [7:0]      c;
      sat_mag = 64'h7FFF_FFFF_FFFF_FFFF;
      src = radix_of(source_reg);
      tgt = radix_of(target_reg);
      chars_in++;

      // equal radices: echo the character as it is
      if (src == tgt) begin
         push_char(sym, last, 1'b0, 1'b0);
         echoed++;
         if (last) clear_number();
         else first_char = 1'b0;
         return;
      end

      if (!bad_seen) begin
         if (first_char && sym == rsc_pkg::CharMinus) begin
            negative = 1'b1;
         end else begin
            d = digit_of(sym);
            dval = d;
            if (d < 0) begin
               bad_seen = 1'b1;
            end else if (magnitude > (sat_mag - dval) / src) begin
               magnitude = sat_mag;
               saturated = 1'b1;
            end else begin
               magnitude = magnitude * src + dval;
            end
         end
      end
      first_char = 1'b0;
      if (!last) return;

      if (bad_seen) begin
         push_char(rsc_pkg::CharNull, 1'b1, 1'b1, 1'b0);
         bad_numbers++;
         clear_number();
         return;
      end

      // split into target digits, least significant first
      neg_out = negative && magnitude != 0;
      cap = rsc_pkg::MaxDigits - (neg_out ? 1 : 0);
      m = magnitude;
      count = 0;
      trunc = 1'b0;
      do begin
         if (count >= cap) begin
            trunc = 1'b1;
            break;
         end
         digit_buf[count] = m % tgt;
         count++;
         m = m / tgt;
      end while (m > 0);

      ovf = saturated || trunc;
      if (ovf) sat_numbers++;
      if (neg_out) push_char(rsc_pkg::CharMinus, 1'b0, 1'b0, ovf);
      for (longint k = count - 1; k >= 0; k--) begin
         if (digit_buf[k] < 10) c = rsc_pkg::CharZero + 8'(digit_buf[k]);
         else c = rsc_pkg::CharUpperA + 8'(digit_buf[k] - 10);
         push_char(c, k == 0, 1'b0, ovf);
      end
      clear_number();
   endfunction

   function void report(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   // Compare one emitted character with the oldest expectation.
   function void check_char(logic [7:0] sym, logic run_end, logic bad, logic ovf);
      char_result_type w;
      chars_out++;
      if (expected_chars.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual symbol %0h", $time, sym);
         errors++;
         return;
      end
      w = expected_chars.pop_front();
      report("out_symbol", w.sym, sym);
      report("run_end", 8'(w.run_end), 8'(run_end));
      report("bad_input", 8'(w.bad), 8'(bad));
      report("overflowed", 8'(w.ovf), 8'(ovf));
      if (w.run_end) numbers_done++;
   endfunction
endclass

module radix_string_converter_unit_tb;
   import rsc_pkg::*;

   localparam int QuietLimit  = 20000;
   localparam int PhaseItems  = 34;
   localparam int PhaseCount  = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [SymW-1:0]     req_symbol = '0;
   logic                req_ends_number = 1'b0;
   logic                rsp_strobe;
   logic [SymW-1:0]     rsp_out_symbol;
   logic                rsp_run_end;
   logic                rsp_bad_input;
   logic                rsp_overflowed;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [AddrBusW-1:0] paddr = '0;
   logic [DataW-1:0]    pwdata = '0;
   logic [DataW-1:0]    prdata;
   logic                pready;

   conversion_scoreboard sb = new();
   bit                   gaps_on = 1'b1;
   int unsigned          quiet_cycles = 0;
   int unsigned          phase_chars;
   int unsigned          settings_used = 1;

   radix_string_converter_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_symbol(req_symbol), .req_ends_number(req_ends_number),
      .rsp_strobe(rsp_strobe), .rsp_out_symbol(rsp_out_symbol),
      .rsp_run_end(rsp_run_end), .rsp_bad_input(rsp_bad_input),
      .rsp_overflowed(rsp_overflowed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_char(rsp_out_symbol, rsp_run_end, rsp_bad_input, rsp_overflowed);
   end

   // abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("Timeout after %0d idle cycles at %0t", quiet_cycles, $time);
         $display("FAILURE");
         $finish;
      end
   end

   // Present one character, with an optional random gap, and hold until transfer.
   task automatic send_item(input logic [7:0] sym, input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start           <= 1'b1;
      req_symbol      <= sym;
      req_ends_number <= last;
      do @(posedge clock); while (busy);
      sb.note_symbol(sym, last);
      phase_chars++;
   endtask

   task automatic send_chars(input logic [7:0] chars[$]);
      foreach (chars[i]) send_item(chars[i], i == chars.size() - 1);
   endtask

   // Drop start and wait until every expected character is out and the block rests.
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.expected_chars.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one radix register, then read it back.
   task automatic write_radix(input logic idx, input logic [5:0] value);
      logic [DataW-1:0] data;
      data = {26'($urandom()), value};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, data[5:0]);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DataW'(data[5:0])) begin
         $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                  $time, idx, data[5:0], prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [7:0] digit_symbol(int unsigned v);
      if (v < 10) return CharZero + 8'(v);
      if ($urandom_range(0, 1)) return CharLowerA + 8'(v - 10);
      return CharUpperA + 8'(v - 10);
   endfunction

   // Build one number: mostly well formed, sometimes broken or noisy.
   task automatic send_number();
      logic [7:0]  chars[$];
      int unsigned kind, len, src, pos;
      kind = $urandom_range(0, 19);
      src  = sb.radix_of(sb.source_reg);
      len  = (kind < 3) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) chars.insert(chars.size(), CharMinus);
      for (int i = 0; i < len; i++) begin
         if (kind == 3) chars.insert(chars.size(), digit_symbol($urandom_range(0, 35)));
         else if (kind == 4) chars.insert(chars.size(), CharZero);
         else chars.insert(chars.size(), digit_symbol($urandom_range(0, src - 1)));
      end
      case (kind)
         5: begin
            pos = $urandom_range(0, chars.size() - 1);
            chars[pos] = 8'($urandom_range(0, 255));
         end
         6: chars.insert($urandom_range(1, chars.size()), CharMinus);
         7: chars = '{CharMinus};
         default: ;
      endcase
      send_chars(chars);
   endtask

   initial begin
      logic [5:0] src_vals[PhaseCount];
      logic [5:0] tgt_vals[PhaseCount];
      src_vals = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd1, 6'd37, 6'd7, 6'd0};
      tgt_vals = '{6'd36, 6'd2, 6'd16, 6'd63, 6'd2, 6'd10, 6'd3, 6'd0};

      // hold reset, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed numbers at the reset radices
      send_chars('{CharZero});
      send_chars('{CharMinus});
      send_chars('{CharMinus, CharUpperZ, CharLowerZ});
      send_chars('{CharZero + 8'd1, CharMinus});
      send_chars('{CharNull});
      send_chars('{8'hFF});
      send_chars('{CharZero + 8'd7, 8'h40, CharNine});
      wait_idle();

      // saturating magnitude
      write_radix(RegSourceRadix, RadixMax);
      write_radix(RegTargetRadix, RadixMin);
      settings_used++;
      send_chars('{CharUpperZ, CharUpperZ, CharUpperZ, CharUpperZ, CharUpperZ,
                   CharUpperZ, CharUpperZ, CharUpperZ, CharUpperZ, CharUpperZ,
                   CharUpperZ, CharUpperZ, CharUpperZ});
      wait_idle();

      // random numbers over a series of radix settings
      for (int p = 0; p < PhaseCount; p++) begin
         if (p == PhaseCount - 1) begin
            src_vals[p] = 6'($urandom_range(0, 63));
            tgt_vals[p] = 6'($urandom_range(0, 63));
            gaps_on = 1'b0;
         end
         write_radix(RegSourceRadix, src_vals[p]);
         write_radix(RegTargetRadix, tgt_vals[p]);
         settings_used++;
         phase_chars = 0;
         while (phase_chars < PhaseItems) send_number();
         wait_idle();
      end

      repeat (16) @(posedge clock);
      $display("Covered %0d character transfers and %0d result transfers over %0d radix settings",
               sb.chars_in, sb.chars_out, settings_used);
      $display("  %0d numbers done: %0d with bad input, %0d saturated, %0d characters echoed",
               sb.numbers_done, sb.bad_numbers, sb.sat_numbers, sb.echoed);
      if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results never seen", sb.errors, sb.expected_chars.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/rsc_pkg.sv
design/radix_string_converter_unit.sv
verif/radix_string_converter_unit_tb.sv
